@@ src/sirdx_pkg.sv @@
// Shared types, constants and helpers for the signed integer to radix text converter.
`timescale 1ns / 1ps
`default_nettype none
package sirdx_pkg;

    localparam int RADIX_W    = 5;
    localparam int SYM_W      = 8;
    localparam int SYMBOLS_W  = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int STEP_BITS  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_RADIX        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [SYM_W-1:0]   MINUS_CHAR  = 8'h2D;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FETCH,
        ST_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic fetch;
        logic emit;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic idx_zero;
    } dp_status_t;

    // Byte code of digit symbol d from the two symbol registers.
    function automatic logic [SYM_W-1:0] symbol_of(
        input logic [SYMBOLS_W-1:0] lo,
        input logic [SYMBOLS_W-1:0] hi,
        input logic [3:0]           d
    );
        logic [2*SYMBOLS_W-1:0] all;
        all = {hi, lo};
        return all[{d, 3'b000} +: SYM_W];
    endfunction

endpackage
`default_nettype wire

@@ src/signed_int_to_radix_digits.sv @@
// Top level: signed integer to radix text converter.
// A value is taken when start is high and busy is low. Its magnitude is divided
// repeatedly by the active radix (2 to MAX_RADIX, saturated) in a restoring
// divider that retires 8 dividend bits a cycle. The digits are then read back
// from a small memory most significant first: the top digit is fetched first,
// during which the '-' is issued for a negative value, then one character per
// cycle is issued. Characters are registered, so each is strobed in the cycle
// after it is issued: the '-' in the cycle after the fetch. The last character
// is strobed in the cycle after busy falls. Every character appears on
// out_char/is_last for exactly one cycle, marked by out_strobe, and the
// receiver cannot stall it. Configuration transfers are taken only while busy
// is low.
`timescale 1ns / 1ps
`default_nettype none
module signed_int_to_radix_digits #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_RADIX  = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output      logic                              busy,
    input  wire logic signed [VALUE_BITS-1:0]      value,
    input  wire logic                              cfg_valid,
    output      logic                              cfg_ready,
    input  wire logic [sirdx_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [sirdx_pkg::SYMBOLS_W-1:0]   cfg_data,
    output      logic                              out_strobe,
    output      logic [sirdx_pkg::SYM_W-1:0]       out_char,
    output      logic                              is_last
);
    import sirdx_pkg::*;

    ctrl_cmd_t            cmd;
    dp_status_t           status;
    logic [RADIX_W-1:0]   active_radix;
    logic [SYMBOLS_W-1:0] symbols_low;
    logic [SYMBOLS_W-1:0] symbols_high;
    logic                 busy_int;

    assign busy      = busy_int;
    assign cfg_ready = !busy_int;

    sirdx_cfg #(
        .MAX_RADIX (MAX_RADIX)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (cfg_valid && !busy_int),
        .wr_index     (cfg_index),
        .wr_data      (cfg_data),
        .active_radix (active_radix),
        .symbols_low  (symbols_low),
        .symbols_high (symbols_high)
    );

    sirdx_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy_int)
    );

    sirdx_dp #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_RADIX  (MAX_RADIX)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .value        (value),
        .active_radix (active_radix),
        .symbols_low  (symbols_low),
        .symbols_high (symbols_high),
        .out_strobe   (out_strobe),
        .out_char     (out_char),
        .is_last      (is_last)
    );

endmodule
`default_nettype wire

@@ src/sirdx_cfg.sv @@
// Configuration registers and radix saturation.
`timescale 1ns / 1ps
`default_nettype none
module sirdx_cfg #(
    parameter int MAX_RADIX = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              wr_en,
    input  wire logic [sirdx_pkg::CFG_IDX_W-1:0]   wr_index,
    input  wire logic [sirdx_pkg::SYMBOLS_W-1:0]   wr_data,
    output      logic [sirdx_pkg::RADIX_W-1:0]     active_radix,
    output      logic [sirdx_pkg::SYMBOLS_W-1:0]   symbols_low,
    output      logic [sirdx_pkg::SYMBOLS_W-1:0]   symbols_high
);
    import sirdx_pkg::*;

    logic [RADIX_W-1:0]   radix_reg;
    logic [SYMBOLS_W-1:0] sym_lo_reg;
    logic [SYMBOLS_W-1:0] sym_hi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg  <= RADIX_RESET;
            sym_lo_reg <= '0;
            sym_hi_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_RADIX:        radix_reg  <= wr_data[RADIX_W-1:0];
                REG_SYMBOLS_LOW:  sym_lo_reg <= wr_data;
                REG_SYMBOLS_HIGH: sym_hi_reg <= wr_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        if (radix_reg < RADIX_MIN)
            active_radix = RADIX_MIN;
        else if (radix_reg > RADIX_W'(MAX_RADIX))
            active_radix = RADIX_W'(MAX_RADIX);
        else
            active_radix = radix_reg;
    end

    assign symbols_low  = sym_lo_reg;
    assign symbols_high = sym_hi_reg;

endmodule
`default_nettype wire

@@ src/sirdx_dp.sv @@
// Datapath: magnitude, chunked restoring divider, digit memory and character output.
`timescale 1ns / 1ps
`default_nettype none
module sirdx_dp #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_RADIX  = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire sirdx_pkg::ctrl_cmd_t              cmd,
    output      sirdx_pkg::dp_status_t             status,
    input  wire logic signed [VALUE_BITS-1:0]      value,
    input  wire logic [sirdx_pkg::RADIX_W-1:0]     active_radix,
    input  wire logic [sirdx_pkg::SYMBOLS_W-1:0]   symbols_low,
    input  wire logic [sirdx_pkg::SYMBOLS_W-1:0]   symbols_high,
    output      logic                              out_strobe,
    output      logic [sirdx_pkg::SYM_W-1:0]       out_char,
    output      logic                              is_last
);
    import sirdx_pkg::*;

    localparam int DIGIT_W = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
    localparam int NCHUNK  = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_W   = NCHUNK * STEP_BITS;
    localparam int CHUNK_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int AW      = $clog2(VALUE_BITS);
    localparam int CW      = $clog2(VALUE_BITS + 1);
    localparam int DEPTH   = 2 ** AW;

    logic [PAD_W-1:0]   quot_reg;
    logic [DIGIT_W-1:0] rem_reg;
    logic [CHUNK_W-1:0] chunk_reg;
    logic [CW-1:0]      cnt_reg;
    logic [AW-1:0]      idx_reg;
    logic               neg_reg;
    logic [DIGIT_W-1:0] rd_data_reg;
    logic               strobe_reg;
    logic [SYM_W-1:0]   char_reg;
    logic               last_reg;

    logic [DIGIT_W-1:0] mem [DEPTH];

    logic [VALUE_BITS-1:0] mag;
    logic                  neg;
    logic [DIGIT_W:0]      divisor;
    logic [DIGIT_W-1:0]    rem_next;
    logic [STEP_BITS-1:0]  qbits;
    logic [PAD_W-1:0]      quot_next;
    logic                  chunk_last;
    logic [AW-1:0]         rd_addr;

    assign neg     = value[VALUE_BITS-1];
    assign mag     = neg ? (~value + 1'b1) : value;
    assign divisor = (DIGIT_W+1)'(active_radix);

    // STEP_BITS steps of restoring division per cycle, dividend bits from the top
    always_comb
    begin
        logic [DIGIT_W-1:0] r;
        logic [DIGIT_W:0]   t;
        r = rem_reg;
        qbits = '0;
        for (int i = 0; i < STEP_BITS; i++)
        begin
            t = {r, quot_reg[PAD_W-1-i]};
            if (t >= divisor)
            begin
                r = DIGIT_W'(t - divisor);
                qbits[STEP_BITS-1-i] = 1'b1;
            end
            else
            begin
                r = t[DIGIT_W-1:0];
            end
        end
        rem_next = r;
    end

    assign quot_next  = PAD_W'({quot_reg, qbits});
    assign chunk_last = (chunk_reg == CHUNK_W'(NCHUNK - 1));

    assign status.div_done = chunk_last &&
                             ((quot_next == '0) || (cnt_reg == CW'(VALUE_BITS - 1)));
    assign status.idx_zero = (idx_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quot_reg  <= '0;
            rem_reg   <= '0;
            chunk_reg <= '0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            neg_reg   <= 1'b0;
        end
        else if (cmd.load)
        begin
            quot_reg  <= PAD_W'(mag);
            rem_reg   <= '0;
            chunk_reg <= '0;
            cnt_reg   <= '0;
            neg_reg   <= neg;
        end
        else if (cmd.div_step)
        begin
            quot_reg <= quot_next;
            if (chunk_last)
            begin
                rem_reg   <= '0;
                chunk_reg <= '0;
                cnt_reg   <= cnt_reg + 1'b1;
                idx_reg   <= cnt_reg[AW-1:0];
            end
            else
            begin
                rem_reg   <= rem_next;
                chunk_reg <= chunk_reg + 1'b1;
            end
        end
        else if (cmd.emit)
        begin
            idx_reg <= idx_reg - 1'b1;
        end
    end

    // Digit memory: least significant digit at address 0
    always_ff @(posedge clk)
    begin
        if (cmd.div_step && chunk_last)
            mem[cnt_reg[AW-1:0]] <= rem_next;
    end

    // Read one address ahead while emitting
    assign rd_addr = cmd.emit ? (idx_reg - 1'b1) : idx_reg;

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= cmd.emit || (cmd.fetch && neg_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            char_reg <= symbol_of(symbols_low, symbols_high, 4'(rd_data_reg));
            last_reg <= (idx_reg == '0);
        end
        else
        begin
            char_reg <= MINUS_CHAR;
            last_reg <= 1'b0;
        end
    end

    assign out_strobe = strobe_reg;
    assign out_char   = char_reg;
    assign is_last    = last_reg;

endmodule
`default_nettype wire

@@ src/sirdx_ctrl.sv @@
// Controller state machine sequencing load, division, fetch and emission.
`timescale 1ns / 1ps
`default_nettype none
module sirdx_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire sirdx_pkg::dp_status_t  status,
    output      sirdx_pkg::ctrl_cmd_t   cmd,
    output      logic                   busy
);
    import sirdx_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                    state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                // sign goes out here while the top digit is read
                cmd.fetch  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (status.idx_zero)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule
`default_nettype wire

@@ tb/sv/tb_signed_int_to_radix_digits.sv @@
// Self-checking testbench for the signed integer to radix text converter.
`timescale 1ns / 1ps
module tb_signed_int_to_radix_digits;
    import sirdx_pkg::*;

    localparam int               VALUE_BITS  = 32;
    localparam logic [4:0]       RADIX_TOP   = 5'd16;
    localparam logic [1:0]       REG_UNUSED  = 2'd3;
    localparam logic [63:0]      DIGITS_0_7  = 64'h3736_3534_3332_3130;
    localparam logic [63:0]      DIGITS_8_F  = 64'h4645_4443_4241_3938;
    localparam int               STALL_LIMIT = 3000;
    localparam int               SETTLE      = 200;

    typedef struct {
        logic [SYM_W-1:0] code;
        logic             last;
    } text_char_t;

    logic                           clk        = 1'b0;
    logic                           rst_n      = 1'b0;
    logic                           start      = 1'b0;
    logic                           busy;
    logic signed [VALUE_BITS-1:0]   value      = '0;
    logic                           cfg_valid  = 1'b0;
    logic                           cfg_ready;
    logic [CFG_IDX_W-1:0]           cfg_index  = '0;
    logic [SYMBOLS_W-1:0]           cfg_data   = '0;
    logic                           out_strobe;
    logic [SYM_W-1:0]               out_char;
    logic                           is_last;

    // our copy of the configuration, updated at each register transfer
    logic [RADIX_W-1:0]   cfg_radix    = RADIX_RESET;
    logic [SYMBOLS_W-1:0] cfg_sym_low  = '0;
    logic [SYMBOLS_W-1:0] cfg_sym_high = '0;

    logic [VALUE_BITS-1:0] values_to_send [$];
    text_char_t            expected_chars [$];

    int gap_left       = 0;
    bit wait_for_drain = 1'b0;
    bit gaps_on        = 1'b0;
    int items_taken    = 0;
    int mismatch_count = 0;
    int stall_cycles   = 0;

    signed_int_to_radix_digits #(
        .VALUE_BITS(VALUE_BITS),
        .MAX_RADIX (16)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .value     (value),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_strobe(out_strobe),
        .out_char  (out_char),
        .is_last   (is_last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [SYM_W-1:0] glyph_for(input logic [3:0] d);
        if (d[3])
            return cfg_sym_high[{d[2:0], 3'b000} +: SYM_W];
        return cfg_sym_low[{d[2:0], 3'b000} +: SYM_W];
    endfunction

    // Expected characters of one value, most significant digit first.
    function automatic void predict_text(input logic [VALUE_BITS-1:0] v);
        logic [VALUE_BITS-1:0] mag;
        logic [RADIX_W-1:0]    base;
        logic [3:0]            digits [VALUE_BITS];
        int                    n;
        text_char_t            c;
        base = cfg_radix;
        if (base < RADIX_MIN)
            base = RADIX_MIN;
        else if (base > RADIX_TOP)
            base = RADIX_TOP;
        // unsigned negation, so the most negative value has a proper magnitude
        mag = v[VALUE_BITS-1] ? '0 - v : v;
        n = 0;
        if (mag == '0)
        begin
            digits[0] = 4'd0;
            n = 1;
        end
        while (mag != '0)
        begin
            digits[n] = 4'(mag % base);
            mag = mag / base;
            n++;
        end
        if (v[VALUE_BITS-1])
        begin
            c.code = MINUS_CHAR;
            c.last = 1'b0;
            expected_chars.push_back(c);
        end
        for (int i = n - 1; i >= 0; i--)
        begin
            c.code = glyph_for(digits[i]);
            c.last = (i == 0);
            expected_chars.push_back(c);
        end
    endfunction

    function automatic int next_gap();
        int roll;
        if (!gaps_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [VALUE_BITS-1:0] pick_value();
        logic [VALUE_BITS-1:0] v;
        case ($urandom_range(0, 9))
            0: v = $urandom_range(0, 40);
            1: v = '0 - $urandom_range(1, 40);
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            3: v = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
            4:
            begin
                v = $urandom_range(0, 65535);
                if ($urandom_range(0, 1))
                    v = '0 - v;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic void note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] mismatch: %s", $time, what);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SYMBOLS_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_RADIX:        cfg_radix    = data[RADIX_W-1:0];
            REG_SYMBOLS_LOW:  cfg_sym_low  = data;
            REG_SYMBOLS_HIGH: cfg_sym_high = data;
            default:          ;
        endcase
    endtask

    // Polled on the falling edge so nothing races the clocked blocks.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (values_to_send.size() != 0 || start || busy || expected_chars.size() != 0);
    endtask

    task automatic set_radix(input logic [RADIX_W-1:0] r);
        logic [SYMBOLS_W-1:0] word;
        word = {$urandom, $urandom};
        word[RADIX_W-1:0] = r;
        write_reg(REG_RADIX, word);
    endtask

    // Driver: one transfer per start/!busy edge, next item offered straight away
    // unless a gap or a drain hold is pending.
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic                  offer;
        logic [VALUE_BITS-1:0] next_value;
        offer      = start;
        next_value = value;
        if (!rst_n)
        begin
            start <= 1'b0;
            value <= '0;
            gap_left       = 0;
            wait_for_drain = 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                predict_text(value);
                items_taken++;
                offer          = 1'b0;
                next_value     = $urandom;
                gap_left       = next_gap();
                wait_for_drain = ($urandom_range(0, 24) == 0) || (items_taken % 40 == 20);
            end
            if (!offer)
            begin
                if (wait_for_drain && expected_chars.size() == 0)
                    wait_for_drain = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (!wait_for_drain && values_to_send.size() != 0)
                begin
                    next_value = values_to_send.pop_front();
                    offer      = 1'b1;
                end
            end
            start <= offer;
            value <= next_value;
        end
    end

    always @(posedge clk)
    begin : monitor
        text_char_t want;
        if (rst_n && out_strobe)
        begin
            if (expected_chars.size() == 0)
                note_mismatch($sformatf("unexpected char 0x%02h last=%0b", out_char, is_last));
            else
            begin
                want = expected_chars.pop_front();
                if (out_char !== want.code || is_last !== want.last)
                    note_mismatch($sformatf("expected char 0x%02h last=%0b, got 0x%02h last=%0b",
                                            want.code, want.last, out_char, is_last));
            end
        end
    end

    // Watchdog: any transfer on any port resets the count.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("** signed_int_to_radix_digits: FAILED **");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: radix ten, every symbol byte zero
        @(negedge clk);
        gaps_on = 1'b0;
        values_to_send = '{32'h0000_0000, 32'hFFFF_FFFB, 32'h0000_04D2};
        wait_drained();

        write_reg(REG_SYMBOLS_LOW, DIGITS_0_7);
        write_reg(REG_SYMBOLS_HIGH, DIGITS_8_F);
        set_radix(5'd10);
        @(negedge clk);
        values_to_send = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0009,
                           32'h0000_000A, 32'hFFFF_FFF6, 32'h7FFF_FFFF, 32'h8000_0000,
                           32'h075B_CD15};
        wait_drained();

        // binary: the most negative value gives the longest text
        set_radix(5'd2);
        @(negedge clk);
        gaps_on = 1'b1;
        values_to_send = '{32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001};
        wait_drained();

        set_radix(5'd16);
        @(negedge clk);
        values_to_send = '{32'h8000_0000, 32'hDEAD_BEEF, 32'h0000_0000, 32'h0000_0010};
        wait_drained();

        // radix values outside 2..16 saturate
        set_radix(5'd0);
        @(negedge clk);
        values_to_send = '{32'hFFFF_FFF9};
        wait_drained();
        set_radix(5'd1);
        @(negedge clk);
        values_to_send = '{32'h0000_0005};
        wait_drained();
        set_radix(5'd17);
        @(negedge clk);
        values_to_send = '{32'h0000_00FF};
        wait_drained();
        set_radix(5'd31);
        @(negedge clk);
        values_to_send = '{32'hFFFF_FF00};
        wait_drained();

        // a write to the spare index must leave everything alone
        write_reg(REG_UNUSED, {$urandom, $urandom});
        @(negedge clk);
        values_to_send = '{32'h0000_0FFF};
        wait_drained();

        for (int p = 0; p < 6; p++)
        begin
            if (p % 2 == 0)
            begin
                if ($urandom_range(0, 1))
                begin
                    write_reg(REG_SYMBOLS_LOW, DIGITS_0_7);
                    write_reg(REG_SYMBOLS_HIGH, DIGITS_8_F);
                end
                else
                begin
                    write_reg(REG_SYMBOLS_HIGH, {$urandom, $urandom});
                    write_reg(REG_SYMBOLS_LOW, {$urandom, $urandom});
                end
            end
            if ($urandom_range(0, 5) == 0)
                set_radix(5'($urandom_range(0, 31)));
            else
                set_radix(5'($urandom_range(2, 16)));
            @(negedge clk);
            gaps_on = (p % 3 != 2);
            repeat (14) values_to_send.push_back(pick_value());
            wait_drained();
        end

        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0 && expected_chars.size() == 0)
            $display("** signed_int_to_radix_digits: PASSED **");
        else
            $display("** signed_int_to_radix_digits: FAILED **");
        $finish;
    end

endmodule
